FILE: hw/rtl/stc_pkg.sv
package stc_pkg;

  // Storage geometry
  localparam int unsigned RAM_BYTES = 8192;
  localparam int unsigned ADDR_W    = $clog2(RAM_BYTES);
  localparam int unsigned STEP_W    = 5;

  // Bus decode: port window is 0x7FF0..0x7FF7, compared on address[15:3]
  localparam logic [12:0] PORT_TAG      = 13'h0FFE;
  localparam logic [2:0]  PORT_TBL_LAST = 3'd3;
  localparam logic [2:0]  PORT_HIGH     = 3'd4;
  localparam logic [2:0]  PORT_SELECT   = 3'd6;

  // Fixed RAM locations
  localparam logic [ADDR_W-1:0] SELECTOR_ADDR = 13'h1FF6;
  localparam logic [ADDR_W-1:0] RECORD_BASE   = 13'h1FF0;
  localparam logic [3:0]        TABLE_TAG     = 4'b1100;    // 0x1800 >> 9
  localparam logic [6:0]        HIGH_TAG      = 7'b1101000; // 0x1A00 >> 6

  // Address source for the RAM port
  typedef enum logic [2:0] {
    AM_BUS,       // request address, masked to the RAM
    AM_RECORD,    // record area byte of the current port
    AM_SELECTOR,  // record selector byte
    AM_TABLE,     // sprite table entry at the table base
    AM_HIGH,      // packed high table byte for the selector
    AM_SLOT,      // selector record, toggle half, port byte
    AM_REC        // selector record, fixed byte offset
  } addr_mode_e;

  // Write data source
  typedef enum logic [2:0] {
    WS_BYTE,      // request byte
    WS_SEVEN,     // request byte, low seven bits
    WS_DATA,      // RAM read data
    WS_MERGE,     // high table byte with two bits merged in
    WS_SEL        // selector register
  } wsrc_e;

  // Step sequencing
  typedef enum logic [1:0] {
    NX_NEXT,
    NX_GOTO,
    NX_PORT,
    NX_DONE
  } next_e;

  typedef struct packed {
    addr_mode_e        am;
    logic              we;
    wsrc_e             ws;
    logic [3:0]        konst;     // byte offset for AM_TABLE / AM_REC
    logic              tbl_port;  // table offset comes from the port number
    logic              ld_sel;    // selector register <= read data
    logic              ld_byte;   // byte register <= read data
    logic              init_sel;  // selector and table index <= byte[6:0], toggles clear
    logic              flip;      // invert toggle of current port
    logic              emit;      // read data goes out this cycle
    next_e             nx;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Program layout
  localparam logic [STEP_W-1:0] STEP_RD0  = 5'd0;
  localparam logic [STEP_W-1:0] STEP_RD1  = 5'd1;
  localparam logic [STEP_W-1:0] STEP_WR0  = 5'd2;
  localparam logic [STEP_W-1:0] STEP_PT0  = 5'd3;
  localparam logic [STEP_W-1:0] STEP_PT1  = 5'd4;
  localparam logic [STEP_W-1:0] STEP_PTA  = 5'd5;
  localparam logic [STEP_W-1:0] STEP_PTH  = 5'd6;
  localparam logic [STEP_W-1:0] STEP_PTH1 = 5'd7;
  localparam logic [STEP_W-1:0] STEP_PTH2 = 5'd8;
  localparam logic [STEP_W-1:0] STEP_SLOT = 5'd9;
  localparam logic [STEP_W-1:0] STEP_PTS  = 5'd10;
  localparam logic [STEP_W-1:0] STEP_S0   = 5'd11;
  localparam logic [STEP_W-1:0] STEP_S1   = 5'd12;
  localparam logic [STEP_W-1:0] STEP_S2   = 5'd13;
  localparam logic [STEP_W-1:0] STEP_S3   = 5'd14;
  localparam logic [STEP_W-1:0] STEP_S4   = 5'd15;
  localparam logic [STEP_W-1:0] STEP_S5   = 5'd16;
  localparam logic [STEP_W-1:0] STEP_S6   = 5'd17;
  localparam logic [STEP_W-1:0] STEP_S7   = 5'd18;
  localparam logic [STEP_W-1:0] STEP_S8   = 5'd19;
  localparam logic [STEP_W-1:0] STEP_S9   = 5'd20;
  localparam logic [STEP_W-1:0] STEP_S10  = 5'd21;
  localparam logic [STEP_W-1:0] STEP_S11  = 5'd22;
  localparam logic [STEP_W-1:0] STEP_S12  = 5'd23;

  localparam ctrl_t NOP_WORD = '{
    am: AM_BUS, we: 1'b0, ws: WS_BYTE, konst: 4'd0, tbl_port: 1'b0,
    ld_sel: 1'b0, ld_byte: 1'b0, init_sel: 1'b0, flip: 1'b0, emit: 1'b0,
    nx: NX_DONE, target: 5'd0
  };

  // Control word with all side flags clear
  function automatic ctrl_t cw(input addr_mode_e am, input logic we, input wsrc_e ws,
                               input logic [3:0] k, input next_e nx,
                               input logic [STEP_W-1:0] tgt);
    ctrl_t w;
    w        = NOP_WORD;
    w.am     = am;
    w.we     = we;
    w.ws     = ws;
    w.konst  = k;
    w.nx     = nx;
    w.target = tgt;
    return w;
  endfunction

  // Microcode store
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = NOP_WORD;
    unique case (step)
      // bus read: address, then data out
      STEP_RD0: w = cw(AM_BUS, 1'b0, WS_BYTE, 4'd0, NX_NEXT, 5'd0);
      STEP_RD1: begin
        w      = cw(AM_BUS, 1'b0, WS_BYTE, 4'd0, NX_DONE, 5'd0);
        w.emit = 1'b1;
      end
      // plain RAM write
      STEP_WR0: w = cw(AM_BUS, 1'b1, WS_BYTE, 4'd0, NX_DONE, 5'd0);
      // ports other than the selector port
      STEP_PT0: w = cw(AM_RECORD, 1'b1, WS_BYTE, 4'd0, NX_NEXT, 5'd0);
      STEP_PT1: w = cw(AM_SELECTOR, 1'b0, WS_BYTE, 4'd0, NX_PORT, 5'd0);
      STEP_PTA: begin
        w          = cw(AM_TABLE, 1'b1, WS_BYTE, 4'd0, NX_GOTO, STEP_SLOT);
        w.tbl_port = 1'b1;
        w.ld_sel   = 1'b1;
      end
      STEP_PTH: begin
        w        = cw(AM_BUS, 1'b0, WS_BYTE, 4'd0, NX_NEXT, 5'd0);
        w.ld_sel = 1'b1;
      end
      STEP_PTH1: w = cw(AM_HIGH, 1'b0, WS_BYTE, 4'd0, NX_NEXT, 5'd0);
      STEP_PTH2: w = cw(AM_HIGH, 1'b1, WS_MERGE, 4'd0, NX_NEXT, 5'd0);
      STEP_SLOT: begin
        w      = cw(AM_SLOT, 1'b1, WS_BYTE, 4'd0, NX_DONE, 5'd0);
        w.flip = 1'b1;
      end
      STEP_PTS: begin
        w        = cw(AM_BUS, 1'b0, WS_BYTE, 4'd0, NX_GOTO, STEP_SLOT);
        w.ld_sel = 1'b1;
      end
      // selector port: pick sprite, copy record into table and high bits
      STEP_S0: begin
        w          = cw(AM_SELECTOR, 1'b1, WS_SEVEN, 4'd0, NX_NEXT, 5'd0);
        w.init_sel = 1'b1;
      end
      STEP_S1:  w = cw(AM_REC,   1'b0, WS_DATA, 4'd3,  NX_NEXT, 5'd0);
      STEP_S2:  w = cw(AM_TABLE, 1'b1, WS_DATA, 4'd0,  NX_NEXT, 5'd0);
      STEP_S3:  w = cw(AM_REC,   1'b0, WS_DATA, 4'd9,  NX_NEXT, 5'd0);
      STEP_S4:  w = cw(AM_TABLE, 1'b1, WS_DATA, 4'd1,  NX_NEXT, 5'd0);
      STEP_S5:  w = cw(AM_REC,   1'b0, WS_DATA, 4'd10, NX_NEXT, 5'd0);
      STEP_S6:  w = cw(AM_TABLE, 1'b1, WS_DATA, 4'd2,  NX_NEXT, 5'd0);
      STEP_S7:  w = cw(AM_REC,   1'b0, WS_DATA, 4'd11, NX_NEXT, 5'd0);
      STEP_S8:  w = cw(AM_TABLE, 1'b1, WS_DATA, 4'd3,  NX_NEXT, 5'd0);
      STEP_S9:  w = cw(AM_REC,   1'b0, WS_DATA, 4'd4,  NX_NEXT, 5'd0);
      STEP_S10: begin
        w         = cw(AM_HIGH, 1'b0, WS_DATA, 4'd0, NX_NEXT, 5'd0);
        w.ld_byte = 1'b1;
      end
      STEP_S11: w = cw(AM_HIGH,  1'b1, WS_MERGE, 4'd0, NX_NEXT, 5'd0);
      STEP_S12: w = cw(AM_REC,   1'b1, WS_SEL,   4'd6, NX_DONE, 5'd0);
      default:  w = NOP_WORD;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/stc_ram.sv
module stc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/stc_seq.sv
module stc_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            launch_i,
  input  logic [stc_pkg::STEP_W-1:0]      entry_i,
  input  logic [2:0]                      port_i,
  output stc_pkg::ctrl_t                  ctrl_o,
  output logic                            run_o
);

  logic [stc_pkg::STEP_W-1:0] upc_q, upc_d;
  logic                       run_q, run_d;
  stc_pkg::ctrl_t             word;

  // step counter and run flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= '0;
      run_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      run_q <= run_d;
    end
  end

  // fetch and sequencing
  always_comb begin
    word  = stc_pkg::ucode_rom(upc_q);
    upc_d = upc_q;
    run_d = run_q;
    if (launch_i) begin
      upc_d = entry_i;
      run_d = 1'b1;
    end else if (run_q) begin
      unique case (word.nx)
        stc_pkg::NX_NEXT: upc_d = upc_q + 1'b1;
        stc_pkg::NX_GOTO: upc_d = word.target;
        stc_pkg::NX_PORT: begin
          priority if (port_i <= stc_pkg::PORT_TBL_LAST) begin
            upc_d = stc_pkg::STEP_PTA;
          end else if (port_i == stc_pkg::PORT_HIGH) begin
            upc_d = stc_pkg::STEP_PTH;
          end else begin
            upc_d = stc_pkg::STEP_PTS;
          end
        end
        stc_pkg::NX_DONE: run_d = 1'b0;
        default:          run_d = 1'b0;
      endcase
    end
  end

  assign ctrl_o = run_q ? word : stc_pkg::NOP_WORD;
  assign run_o  = run_q;

endmodule

FILE: hw/rtl/sprite_table_coprocessor.sv
// Channel   | Ports                                      | Handshake
// ----------+--------------------------------------------+---------------------------
// request   | opcode_i, address_i, write_data_i          | start && !busy
// read data | read_data_o                                | read_valid_o, one cycle
//
// A request is taken when start is high and busy is low; busy stays high until the
// microcode program for it has ended, one RAM access per step on a single-port RAM.
// After reset the RAM is swept to zero, one byte a cycle, with busy high until the sweep ends.
// Read data is shown for exactly one cycle; the receiver cannot hold it off.
module sprite_table_coprocessor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        read_valid_o,
  output logic [7:0]  read_data_o
);

  localparam int unsigned AW = stc_pkg::ADDR_W;

  stc_pkg::ctrl_t             ctrl;
  logic                       run;
  logic                       launch;
  logic [stc_pkg::STEP_W-1:0] entry;
  logic                       is_port;

  // request registers
  logic [AW-1:0] addr_q;
  logic [2:0]    port_q;
  logic [7:0]    byte_q, byte_d;
  logic [7:0]    sel_q, sel_d;

  // control state
  logic [6:0]    tidx_q, tidx_d;
  logic [7:0]    toggle_q, toggle_d;
  logic [AW-1:0] clr_q;
  logic          clr_busy_q;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic [AW-1:0] seq_addr;
  logic [7:0]    seq_wdata;
  logic [1:0]    tbl_off;
  logic [2:0]    shift;
  logic [7:0]    merge_mask;
  logic [7:0]    merged;

  assign busy   = clr_busy_q | run;
  assign launch = start & ~busy;

  // entry point of the program for this request
  assign is_port = (address_i[15:3] == stc_pkg::PORT_TAG);
  always_comb begin
    priority if (!opcode_i) begin
      entry = stc_pkg::STEP_RD0;
    end else if (is_port && address_i[2:0] == stc_pkg::PORT_SELECT) begin
      entry = stc_pkg::STEP_S0;
    end else if (is_port) begin
      entry = stc_pkg::STEP_PT0;
    end else begin
      entry = stc_pkg::STEP_WR0;
    end
  end

  stc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .launch_i (launch),
    .entry_i  (entry),
    .port_i   (port_q),
    .ctrl_o   (ctrl),
    .run_o    (run)
  );

  // request capture
  always_ff @(posedge clk_i) begin
    if (launch) begin
      addr_q <= address_i[AW-1:0];
      port_q <= address_i[2:0];
    end
    byte_q <= byte_d;
    sel_q  <= sel_d;
  end

  always_comb begin
    byte_d = byte_q;
    sel_d  = sel_q;
    if (launch) begin
      byte_d = write_data_i;
    end else if (ctrl.ld_byte) begin
      byte_d = ram_rdata;
    end
    if (ctrl.ld_sel) begin
      sel_d = ram_rdata;
    end else if (ctrl.init_sel) begin
      sel_d = {1'b0, byte_q[6:0]};
    end
  end

  // table index and toggles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tidx_q   <= '0;
      toggle_q <= '0;
    end else begin
      tidx_q   <= tidx_d;
      toggle_q <= toggle_d;
    end
  end

  always_comb begin
    tidx_d   = tidx_q;
    toggle_d = toggle_q;
    if (ctrl.init_sel) begin
      tidx_d   = byte_q[6:0];
      toggle_d = '0;
    end else if (ctrl.flip) begin
      toggle_d[port_q] = ~toggle_q[port_q];
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (&clr_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // table offset: port 3 picks byte 0 or 3 by its toggle
  always_comb begin
    if (!ctrl.tbl_port) begin
      tbl_off = ctrl.konst[1:0];
    end else if (port_q == stc_pkg::PORT_TBL_LAST) begin
      tbl_off = toggle_q[stc_pkg::PORT_TBL_LAST] ? 2'd3 : 2'd0;
    end else begin
      tbl_off = port_q[1:0];
    end
  end

  // address generation
  always_comb begin
    unique case (ctrl.am)
      stc_pkg::AM_BUS:      seq_addr = addr_q;
      stc_pkg::AM_RECORD:   seq_addr = stc_pkg::RECORD_BASE | {10'd0, port_q};
      stc_pkg::AM_SELECTOR: seq_addr = stc_pkg::SELECTOR_ADDR;
      stc_pkg::AM_TABLE:    seq_addr = {stc_pkg::TABLE_TAG, tidx_q, tbl_off};
      stc_pkg::AM_HIGH:     seq_addr = {stc_pkg::HIGH_TAG, sel_q[7:2]};
      stc_pkg::AM_SLOT:     seq_addr = {1'b0, sel_q, toggle_q[port_q], port_q};
      stc_pkg::AM_REC:      seq_addr = {1'b0, sel_q, ctrl.konst};
      default:              seq_addr = addr_q;
    endcase
  end

  // two-bit merge into a high table byte
  assign shift      = {sel_q[1:0], 1'b0};
  assign merge_mask = 8'd3 << shift;
  assign merged     = (ram_rdata & ~merge_mask) | ({6'd0, byte_q[1:0]} << shift);

  always_comb begin
    unique case (ctrl.ws)
      stc_pkg::WS_BYTE:  seq_wdata = byte_q;
      stc_pkg::WS_SEVEN: seq_wdata = {1'b0, byte_q[6:0]};
      stc_pkg::WS_DATA:  seq_wdata = ram_rdata;
      stc_pkg::WS_MERGE: seq_wdata = merged;
      stc_pkg::WS_SEL:   seq_wdata = sel_q;
      default:           seq_wdata = byte_q;
    endcase
  end

  // RAM port: sweep has the port until it ends
  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = ctrl.we;
      ram_addr  = seq_addr;
      ram_wdata = seq_wdata;
    end
  end

  stc_ram #(
    .WIDTH (8),
    .DEPTH (stc_pkg::RAM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign read_valid_o = ctrl.emit;
  assign read_data_o  = ram_rdata;

endmodule

FILE: verif/sprite_table_coprocessor_test.sv
module sprite_table_coprocessor_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Bus codes and fixed locations
  localparam logic        OP_READ        = 1'b0;
  localparam logic        OP_WRITE       = 1'b1;
  localparam logic [15:0] PORT_WINDOW    = 16'h7FF0;
  localparam logic [12:0] TABLE_BASE_ADDR = 13'h1800;
  localparam logic [12:0] HIGH_BASE_ADDR = 13'h1A00;
  localparam int          MAX_SHOWN      = 10;
  localparam int          DRAIN_CYCLES   = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        opcode_i;
  logic [15:0] address_i;
  logic [7:0]  write_data_i;
  logic        read_valid_o;
  logic [7:0]  read_data_o;

  // Shadow copy of the coprocessor state
  logic [7:0] shadow_ram [0:stc_pkg::RAM_BYTES-1];
  logic [7:0] shadow_toggle;
  logic [6:0] shadow_index;

  logic [7:0] expected_reads [$];
  logic [7:0] oldest_read;
  int         fault_count;
  int         shown_count;
  bit         no_idle;

  sprite_table_coprocessor u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .read_valid_o (read_valid_o),
    .read_data_o  (read_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Two high-table bits for one sprite
  function automatic void merge_high_bits(input logic [7:0] sel, input logic [1:0] bits);
    logic [12:0] addr;
    logic [2:0]  shift;
    addr  = HIGH_BASE_ADDR + 13'(sel[7:2]);
    shift = {sel[1:0], 1'b0};
    shadow_ram[addr] = (shadow_ram[addr] & ~(8'h03 << shift)) | (8'(bits) << shift);
  endfunction

  // Port write effect on the shadow state
  function automatic void apply_port_write(input logic [2:0] port, input logic [7:0] b);
    logic [12:0] base;
    logic [12:0] rec;
    logic [12:0] tbl;
    logic [7:0]  sel;
    logic [6:0]  v;
    if (port == stc_pkg::PORT_SELECT) begin
      v   = b[6:0];
      rec = {2'b00, v, 4'b0000};
      tbl = TABLE_BASE_ADDR + {4'b0000, v, 2'b00};
      shadow_ram[stc_pkg::SELECTOR_ADDR] = {1'b0, v};
      shadow_index  = v;
      shadow_toggle = '0;
      shadow_ram[tbl]      = shadow_ram[rec + 13'd3];
      shadow_ram[tbl + 1]  = shadow_ram[rec + 13'd9];
      shadow_ram[tbl + 2]  = shadow_ram[rec + 13'd10];
      shadow_ram[tbl + 3]  = shadow_ram[rec + 13'd11];
      merge_high_bits({1'b0, v}, shadow_ram[rec + 13'd4][1:0]);
      shadow_ram[rec + 13'd6] = {1'b0, v};
    end else begin
      shadow_ram[stc_pkg::RECORD_BASE + 13'(port)] = b;
      sel  = shadow_ram[stc_pkg::SELECTOR_ADDR];
      base = TABLE_BASE_ADDR + {4'b0000, shadow_index, 2'b00};
      if (port < stc_pkg::PORT_TBL_LAST) begin
        shadow_ram[base + 13'(port)] = b;
      end else if (port == stc_pkg::PORT_TBL_LAST) begin
        shadow_ram[base + (shadow_toggle[port] ? 13'd3 : 13'd0)] = b;
      end else if (port == stc_pkg::PORT_HIGH) begin
        merge_high_bits(sel, b[1:0]);
      end
      shadow_ram[{1'b0, sel, shadow_toggle[port], port}] = b;
      shadow_toggle[port] = ~shadow_toggle[port];
    end
  endfunction

  // Expected effect of one accepted request
  function automatic void predict_request(input logic op, input logic [15:0] addr,
                                          input logic [7:0] data);
    if (op == OP_READ) begin
      expected_reads.push_back(shadow_ram[addr[12:0]]);
    end else if (addr[15:3] == stc_pkg::PORT_TAG) begin
      apply_port_write(addr[2:0], data);
    end else begin
      shadow_ram[addr[12:0]] = data;
    end
  endfunction

  // Drive one request after a random gap, return at the accepting edge
  task automatic issue_request(input logic op, input logic [15:0] addr, input logic [7:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    write_data_i <= data;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_request(op, addr, data);
  endtask

  task automatic read_byte(input logic [15:0] addr);
    issue_request(OP_READ, addr, 8'($urandom));
  endtask

  task automatic write_byte(input logic [15:0] addr, input logic [7:0] data);
    issue_request(OP_WRITE, addr, data);
  endtask

  // Address biased toward the table, high table, record area and records
  function automatic logic [15:0] pick_address();
    logic [12:0] low;
    case ($urandom_range(0, 4))
      0: low = TABLE_BASE_ADDR + 13'($urandom_range(0, 'h1FF));
      1: low = HIGH_BASE_ADDR + 13'($urandom_range(0, 'h3F));
      2: low = stc_pkg::RECORD_BASE + 13'($urandom_range(0, 7));
      3: low = 13'($urandom_range(0, 'hFFF));
      default: low = 13'($urandom);
    endcase
    return {3'($urandom), low};
  endfunction

  // Reads compared with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && read_valid_o === 1'b1) begin
      if (expected_reads.size() == 0) begin
        fault_count++;
        if (shown_count < MAX_SHOWN) begin
          shown_count++;
          $display("%0t: read data %02h with no read pending", $realtime, read_data_o);
        end
      end else begin
        oldest_read = expected_reads.pop_front();
        if (read_data_o !== oldest_read) begin
          fault_count++;
          if (shown_count < MAX_SHOWN) begin
            shown_count++;
            $display("%0t: read data mismatch: expected %02h, got %02h",
                     $realtime, oldest_read, read_data_o);
          end
        end
      end
    end
  end

  // Cleared RAM after reset, at both ends of the bus
  task automatic test_reset_state();
    read_byte(16'h0000);
    read_byte(16'hFFFF);
  endtask

  // Plain RAM access, masking and the edges of the port window
  task automatic test_plain_access();
    write_byte(16'hFFFF, 8'hFF);
    read_byte(16'h1FFF);
    write_byte(16'h7FEF, 8'h5A);
    write_byte(16'h7FF8, 8'hA5);
    read_byte(16'h1FEF);
    read_byte(16'hFFF8);
  endtask

  // Every non-select port, port 3 at both toggle values
  task automatic test_data_ports();
    write_byte(PORT_WINDOW + 16'd0, 8'h11);
    write_byte(PORT_WINDOW + 16'd1, 8'h22);
    write_byte(PORT_WINDOW + 16'd2, 8'h00);
    write_byte(PORT_WINDOW + 16'd3, 8'h33);
    write_byte(PORT_WINDOW + 16'd3, 8'h44);
    write_byte(PORT_WINDOW + 16'd4, 8'hFF);
    write_byte(PORT_WINDOW + 16'd5, 8'h55);
    write_byte(PORT_WINDOW + 16'd7, 8'h77);
    read_byte(16'h1800);
    read_byte(16'h1803);
    read_byte(16'h1A00);
    read_byte(16'h000B);
  endtask

  // Select port on the last sprite, top bit of the byte dropped
  task automatic test_select_port();
    write_byte(16'h07F3, 8'hC3);
    write_byte(16'h07F4, 8'h02);
    write_byte(PORT_WINDOW + 16'(stc_pkg::PORT_SELECT), 8'hFF);
    read_byte(16'h19FC);
    read_byte(16'h1A1F);
    read_byte(16'h07F6);
  endtask

  // Selector set by a plain write to 255, table index left alone
  task automatic test_selector_direct();
    write_byte(16'h3FF6, 8'hFF);
    write_byte(PORT_WINDOW + 16'(stc_pkg::PORT_HIGH), 8'h03);
    write_byte(PORT_WINDOW + 16'd1, 8'h77);
    read_byte(16'h1A3F);
    read_byte(16'h0FF1);
    read_byte(16'h19FD);
  endtask

  // Mixed traffic, heavy on port writes and reads of the built tables
  task automatic test_random_traffic(input int count);
    int          pick;
    logic [2:0]  port;
    logic [2:0]  bank;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        read_byte(pick_address());
      end else if (pick < 75) begin
        port = 3'($urandom_range(0, 7));
        write_byte(PORT_WINDOW + 16'(port), 8'($urandom));
      end else if (pick < 80) begin
        // selector mirrors, skipping the one inside the port window
        bank = 3'($urandom_range(0, 6));
        if (bank >= 3'd3) bank = bank + 3'd1;
        write_byte({bank, stc_pkg::SELECTOR_ADDR}, 8'($urandom));
      end else begin
        write_byte(pick_address(), 8'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    opcode_i     <= 1'b0;
    address_i    <= '0;
    write_data_i <= '0;
    fault_count  = 0;
    shown_count  = 0;
    no_idle      = 1'b0;
    shadow_toggle = '0;
    shadow_index  = '0;
    for (int a = 0; a < stc_pkg::RAM_BYTES; a++) shadow_ram[a] = 8'h00;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_plain_access();
    test_data_ports();
    test_select_port();
    test_selector_direct();
    test_random_traffic(700);
    start <= 1'b0;

    // drain outstanding reads
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_reads.size() != 0) begin
      fault_count++;
      $display("%0d reads never returned", expected_reads.size());
    end

    if (fault_count == 0) begin
      $display("sprite_table_coprocessor regression: pass");
    end else begin
      $display("sprite_table_coprocessor regression: fail");
    end
    $finish;
  end

  // Watchdog: covers the reset sweep and the slowest traffic several times over
  initial begin
    #3_000_000;
    $display("sprite_table_coprocessor regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/stc_pkg.sv
hw/rtl/stc_ram.sv
hw/rtl/stc_seq.sv
hw/rtl/sprite_table_coprocessor.sv
verif/sprite_table_coprocessor_test.sv
